[rtl/lzssd_pkg.sv]
// Shared types and constants for the LZSS flag-byte decoder.
// No dependencies; imported by lzssd_history, lzss_flag_byte_decoder and the testbench.
package lzssd_pkg;

  // History sizing
  localparam int unsigned HistDepth = 512;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned PosW      = HistAw + 1;
  localparam int unsigned Lanes     = 8;
  localparam int unsigned RowAw     = HistAw - 3;
  localparam int unsigned BankAw    = RowAw - 1;

  // One compressed input byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } lzssd_in_t;

  // One group of decoded bytes
  typedef struct packed {
    logic [7:0] lane0;
    logic [7:0] lane1;
    logic [7:0] lane2;
    logic [7:0] lane3;
    logic [7:0] lane4;
    logic [7:0] lane5;
    logic [7:0] lane6;
    logic [7:0] lane7;
    logic [3:0] lane_count;
    logic       run_last;
    logic       stream_done;
    logic       bad_reference;
  } lzssd_out_t;

  // Write request into the history: up to eight bytes from addr upward
  typedef struct packed {
    logic [HistAw-1:0]    addr;
    logic [Lanes-1:0]     mask;
    logic [Lanes*8-1:0]   data;
  } lzssd_wr_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_OFFSET,
    PH_LENGTH,
    PH_LITERAL
  } lzssd_phase_e;

  typedef enum logic {
    ST_PARSE,
    ST_COPY
  } lzssd_state_e;

endpackage

[rtl/lzssd_history.sv]
// Decoded-byte history: two banks of eight-byte rows (even and odd rows).
// Reads and writes eight bytes at any byte address. Depends on lzssd_pkg.
module lzssd_history import lzssd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [HistAw-1:0]   rd_addr_i,
  output logic [Lanes*8-1:0]  rd_data_o,
  input  lzssd_wr_t           wr_i
);

  localparam int unsigned RowW = Lanes * 8;
  localparam int unsigned Rows = 1 << BankAw;

  logic [RowW-1:0] mem_even [Rows];
  logic [RowW-1:0] mem_odd  [Rows];

  logic [RowAw-1:0]  rd_row0, rd_row1, wr_row0, wr_row1;
  logic [BankAw-1:0] rd_even_addr, rd_odd_addr, wr_even_addr, wr_odd_addr;
  logic [2*RowW-1:0] wr_wide;
  logic [2*Lanes-1:0] wr_be;
  logic [RowW-1:0]   wr_even_data, wr_odd_data;
  logic [Lanes-1:0]  wr_even_be, wr_odd_be;
  logic [RowW-1:0]   even_rdata_q, odd_rdata_q;
  logic [3:0]        rd_sel_q;
  logic [RowW-1:0]   rd_lo, rd_hi;
  logic [2*RowW-1:0] rd_window;

  // Route the two rows of an unaligned read to the banks
  assign rd_row0      = rd_addr_i[HistAw-1:3];
  assign rd_row1      = rd_row0 + RowAw'(1);
  assign rd_even_addr = rd_row0[0] ? rd_row1[RowAw-1:1] : rd_row0[RowAw-1:1];
  assign rd_odd_addr  = rd_row0[0] ? rd_row0[RowAw-1:1] : rd_row1[RowAw-1:1];

  // Align write data and byte enables across two rows
  assign wr_row0 = wr_i.addr[HistAw-1:3];
  assign wr_row1 = wr_row0 + RowAw'(1);
  assign wr_wide = {{RowW{1'b0}}, wr_i.data} << {wr_i.addr[2:0], 3'b000};
  assign wr_be   = {{Lanes{1'b0}}, wr_i.mask} << wr_i.addr[2:0];

  always_comb begin
    if (wr_row0[0]) begin
      wr_odd_addr  = wr_row0[RowAw-1:1];
      wr_odd_data  = wr_wide[RowW-1:0];
      wr_odd_be    = wr_be[Lanes-1:0];
      wr_even_addr = wr_row1[RowAw-1:1];
      wr_even_data = wr_wide[2*RowW-1:RowW];
      wr_even_be   = wr_be[2*Lanes-1:Lanes];
    end else begin
      wr_even_addr = wr_row0[RowAw-1:1];
      wr_even_data = wr_wide[RowW-1:0];
      wr_even_be   = wr_be[Lanes-1:0];
      wr_odd_addr  = wr_row1[RowAw-1:1];
      wr_odd_data  = wr_wide[2*RowW-1:RowW];
      wr_odd_be    = wr_be[2*Lanes-1:Lanes];
    end
  end

  // Bank storage: byte-enabled write, registered read (old data on collision)
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < Lanes; b++) begin
      if (wr_even_be[b]) mem_even[wr_even_addr][b*8 +: 8] <= wr_even_data[b*8 +: 8];
      if (wr_odd_be[b])  mem_odd[wr_odd_addr][b*8 +: 8]   <= wr_odd_data[b*8 +: 8];
    end
    even_rdata_q <= mem_even[rd_even_addr];
    odd_rdata_q  <= mem_odd[rd_odd_addr];
  end

  // Hold row parity and byte offset of the read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_sel_q <= '0;
    end else begin
      rd_sel_q <= rd_addr_i[3:0];
    end
  end

  // Extract eight bytes starting at the read address
  assign rd_lo     = rd_sel_q[3] ? odd_rdata_q : even_rdata_q;
  assign rd_hi     = rd_sel_q[3] ? even_rdata_q : odd_rdata_q;
  assign rd_window = {rd_hi, rd_lo} >> {rd_sel_q[2:0], 3'b000};
  assign rd_data_o = rd_window[RowW-1:0];

endmodule

[rtl/lzss_flag_byte_decoder.sv]
// LZSS flag-byte decoder top level: parser, copy sequencer, output register.
// Depends on lzssd_pkg and lzssd_history.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (lzssd_in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (lzssd_out_t)
//
// Flag, offset and length bytes are parsed. Taking a literal (which
// closes a match, if any) starts the first history read; then one result of
// up to eight bytes per cycle follows while the output is not stalled, paced
// by the eight-byte read window of the two-bank history.
// Reset clears the parser and the output valid; history contents are not
// cleared. A stalled output holds the sequencer and the input in place.
module lzss_flag_byte_decoder import lzssd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lzssd_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output lzssd_out_t out_data_o
);

  lzssd_state_e state_q, state_d;
  lzssd_phase_e phase_q, phase_d;
  logic [7:0]        flag_q, flag_d;
  logic [2:0]        bitpos_q, bitpos_d;
  logic [7:0]        off_q, off_d;
  logic [7:0]        len_q, len_d;
  logic [PosW-1:0]   out_pos_q, out_pos_d;
  logic [HistAw-1:0] copy_src_q, copy_src_d;
  logic [7:0]        copy_left_q, copy_left_d;
  logic [7:0]        lit_q, lit_d;
  logic              last_q, last_d;
  logic              bad_q, bad_d;
  logic              out_valid_q, out_valid_d;
  lzssd_out_t        out_q, out_d;

  logic              out_free, in_acc;
  logic [HistAw-1:0] rd_addr;
  logic [Lanes*8-1:0] rd_data;
  lzssd_wr_t         hist_wr;

  logic [PosW-1:0]   avail, room;
  logic              ref_bad;
  logic [7:0]        ref_n;
  logic              grp_final;
  logic [3:0]        grp_cnt, st_cnt;
  logic [7:0]        grp_lane [Lanes];
  logic [Lanes-1:0]  st_mask;

  lzssd_history u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (hist_wr)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_PARSE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Clip the match at the first byte not yet produced in this stream
  assign avail   = ({2'b00, off_q} < out_pos_q) ? out_pos_q - {2'b00, off_q} : '0;
  assign ref_bad = {2'b00, len_q} > avail;
  assign ref_n   = ref_bad ? avail[7:0] : len_q;

  // Build the current group: copied bytes, then the literal
  assign grp_final = (copy_left_q[7:3] == 5'd0);
  assign grp_cnt   = grp_final ? {1'b0, copy_left_q[2:0]} + 4'd1 : 4'd8;

  always_comb begin
    for (int j = 0; j < Lanes; j++) begin
      if (8'(j) < copy_left_q) begin
        grp_lane[j] = rd_data[j*8 +: 8];
      end else if (8'(j) == copy_left_q) begin
        grp_lane[j] = lit_q;
      end else begin
        grp_lane[j] = 8'd0;
      end
    end
  end

  // Store only what still fits in the history
  assign room   = PosW'(HistDepth) - out_pos_q;
  assign st_cnt = ({{(PosW-4){1'b0}}, grp_cnt} > room) ? room[3:0] : grp_cnt;

  always_comb begin
    for (int j = 0; j < Lanes; j++) begin
      st_mask[j] = 4'(j) < st_cnt;
    end
  end

  // Next state, history access and output loading
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    flag_d      = flag_q;
    bitpos_d    = bitpos_q;
    off_d       = off_q;
    len_d       = len_q;
    out_pos_d   = out_pos_q;
    copy_src_d  = copy_src_q;
    copy_left_d = copy_left_q;
    lit_d       = lit_q;
    last_d      = last_q;
    bad_d       = bad_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = copy_src_q;

    hist_wr.addr = out_pos_q[HistAw-1:0];
    hist_wr.mask = '0;
    hist_wr.data = {grp_lane[7], grp_lane[6], grp_lane[5], grp_lane[4],
                    grp_lane[3], grp_lane[2], grp_lane[1], grp_lane[0]};

    case (state_q)
      ST_PARSE: begin
        rd_addr = HistAw'(off_q);
        if (in_acc) begin
          case (phase_q)
            PH_FLAG: begin
              flag_d   = in_data_i.in_byte;
              bitpos_d = 3'd7;
              off_d    = '0;
              len_d    = '0;
              phase_d  = in_data_i.in_byte[7] ? PH_OFFSET : PH_LITERAL;
            end
            PH_OFFSET: begin
              off_d   = in_data_i.in_byte;
              phase_d = PH_LENGTH;
            end
            PH_LENGTH: begin
              len_d   = in_data_i.in_byte;
              phase_d = PH_LITERAL;
            end
            PH_LITERAL: begin
              copy_src_d  = HistAw'(off_q);
              copy_left_d = ref_n;
              lit_d       = in_data_i.in_byte;
              last_d      = in_data_i.stream_last;
              bad_d       = ref_bad;
              state_d     = ST_COPY;
              off_d       = '0;
              len_d       = '0;
              if (bitpos_q == 3'd0) begin
                phase_d = PH_FLAG;
              end else begin
                bitpos_d = bitpos_q - 3'd1;
                phase_d  = flag_q[bitpos_q - 3'd1] ? PH_OFFSET : PH_LITERAL;
              end
            end
            default: begin
              phase_d = PH_FLAG;
            end
          endcase

          // Stream end: reset the parser; a header byte yields an empty result
          if (in_data_i.stream_last) begin
            phase_d  = PH_FLAG;
            flag_d   = '0;
            bitpos_d = 3'd7;
            off_d    = '0;
            len_d    = '0;
            if (phase_q != PH_LITERAL) begin
              out_pos_d         = '0;
              out_valid_d       = 1'b1;
              out_d             = '0;
              out_d.run_last    = 1'b1;
              out_d.stream_done = 1'b1;
            end
          end
        end
      end

      ST_COPY: begin
        if (out_free) begin
          // Emit and store one group, then advance the read window
          out_valid_d         = 1'b1;
          out_d.lane0         = grp_lane[0];
          out_d.lane1         = grp_lane[1];
          out_d.lane2         = grp_lane[2];
          out_d.lane3         = grp_lane[3];
          out_d.lane4         = grp_lane[4];
          out_d.lane5         = grp_lane[5];
          out_d.lane6         = grp_lane[6];
          out_d.lane7         = grp_lane[7];
          out_d.lane_count    = grp_cnt;
          out_d.run_last      = grp_final;
          out_d.stream_done   = grp_final && last_q;
          out_d.bad_reference = bad_q;
          hist_wr.mask        = st_mask;
          out_pos_d           = out_pos_q + PosW'(st_cnt);
          copy_src_d          = copy_src_q + HistAw'(Lanes);
          rd_addr             = copy_src_q + HistAw'(Lanes);
          if (grp_final) begin
            state_d = ST_PARSE;
            if (last_q) out_pos_d = '0;
          end else begin
            copy_left_d = copy_left_q - 8'd8;
          end
        end
      end

      default: begin
        state_d = ST_PARSE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      phase_q     <= PH_FLAG;
      flag_q      <= '0;
      bitpos_q    <= 3'd7;
      off_q       <= '0;
      len_q       <= '0;
      out_pos_q   <= '0;
      copy_src_q  <= '0;
      copy_left_q <= '0;
      last_q      <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      flag_q      <= flag_d;
      bitpos_q    <= bitpos_d;
      off_q       <= off_d;
      len_q       <= len_d;
      out_pos_q   <= out_pos_d;
      copy_src_q  <= copy_src_d;
      copy_left_q <= copy_left_d;
      last_q      <= last_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lit_q <= lit_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Only the final group of a run may be short
  a_short_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_last |-> out_data_o.lane_count == 4'd8)
    else $error("non-final group is not full");

  // An empty result only marks stream end
  a_empty_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.lane_count == 4'd0) |-> out_data_o.stream_done)
    else $error("empty result without stream end");

  // Output position stays within the history
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pos_q <= PosW'(HistDepth))
    else $error("output position beyond history depth");

  // Closing the last run of a stream rewinds the output position
  a_pos_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) && out_free && grp_final && last_q |=> out_pos_q == '0)
    else $error("output position not rewound at stream end");

endmodule

[bench/tb_lzss_flag_byte_decoder.sv]
// Testbench for lzss_flag_byte_decoder: directed rows, then random streams,
// each request predicted in the bench and checked field by field.
// Depends on lzssd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_lzss_flag_byte_decoder;
  import lzssd_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 12;
  localparam int DirRows       = 25;
  localparam int RandomItems   = 235;
  localparam int SlowRxItems   = 95;
  localparam int SlowTxItems   = 190;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 64;
  localparam int WatchdogLimit = 3000;

  // Pacing of the two channels
  typedef enum logic [1:0] {
    PACE_SLOW_RX,
    PACE_SLOW_TX,
    PACE_FULL
  } pace_e;

  // One directed row: the request and, where typed, its single expected group
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       typed;
    logic [3:0] count;
    logic       bad;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  lzssd_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  lzssd_out_t out_data_o;

  pace_e       idle_mode = PACE_SLOW_RX;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned req_count = 0;
  int unsigned random_count = 0;
  int unsigned group_count = 0;
  int unsigned fail_count = 0;
  int unsigned stream_len = 0;

  // Decoder state as the bench tracks it
  lzssd_phase_e dec_phase;
  logic [7:0]   dec_flags;
  logic [2:0]   dec_bit;
  logic [7:0]   dec_offset;
  logic [7:0]   dec_length;
  int unsigned  dec_pos;
  logic [7:0]   dec_history [HistDepth];

  lzssd_out_t fresh_groups [$];
  lzssd_out_t expected_groups [$];

  dir_row_t   dir_rows [DirRows];
  lzssd_out_t want_group;
  logic [63:0] got_lanes;
  logic [63:0] want_lanes;
  int          lane_idx;

  lzss_flag_byte_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Pick the next token kind from the current flag bit
  function automatic void begin_token();
    dec_offset = 8'h00;
    dec_length = 8'h00;
    dec_phase  = dec_flags[dec_bit] ? PH_OFFSET : PH_LITERAL;
  endfunction

  // Return the parser to its start-of-stream state
  function automatic void restart_stream();
    dec_phase  = PH_FLAG;
    dec_flags  = 8'h00;
    dec_bit    = 3'd7;
    dec_offset = 8'h00;
    dec_length = 8'h00;
    dec_pos    = 0;
  endfunction

  // Advance the decoder by one byte and collect the groups it emits
  task automatic decode_request(input logic [7:0] code, input logic last);
    logic [7:0]  run [$];
    logic        clipped;
    int unsigned k;
    int unsigned pos;
    int unsigned cnt;
    int unsigned j;
    logic [63:0] lanes;
    lzssd_out_t  grp;
    clipped = 1'b0;
    fresh_groups.delete();
    case (dec_phase)
      PH_FLAG: begin
        dec_flags = code;
        dec_bit   = 3'd7;
        begin_token();
      end
      PH_OFFSET: begin
        dec_offset = code;
        dec_phase  = PH_LENGTH;
      end
      PH_LENGTH: begin
        dec_length = code;
        dec_phase  = PH_LITERAL;
      end
      default: begin
        // copy only bytes already written in this stream; stop at the first other
        k = 0;
        while (k < dec_length && !clipped) begin
          if (dec_offset + k >= dec_pos) begin
            clipped = 1'b1;
          end else begin
            run.push_back(dec_history[dec_offset + k]);
            k++;
          end
        end
        run.push_back(code);
        // store into history until it is full, then drop
        foreach (run[i]) begin
          if (dec_pos < HistDepth) begin
            dec_history[dec_pos] = run[i];
            dec_pos++;
          end
        end
        if (dec_bit == 3'd0) begin
          dec_phase  = PH_FLAG;
          dec_offset = 8'h00;
          dec_length = 8'h00;
        end else begin
          dec_bit--;
          begin_token();
        end
      end
    endcase
    // split the run into groups of up to eight lanes
    pos = 0;
    while (pos < run.size() || (last && fresh_groups.size() == 0)) begin
      cnt = run.size() - pos;
      if (cnt > Lanes) cnt = Lanes;
      lanes = '0;
      for (j = 0; j < cnt; j++) lanes[63 - 8 * j -: 8] = run[pos + j];
      pos += cnt;
      grp = '0;
      {grp.lane0, grp.lane1, grp.lane2, grp.lane3,
       grp.lane4, grp.lane5, grp.lane6, grp.lane7} = lanes;
      grp.lane_count    = 4'(cnt);
      grp.run_last      = (pos >= run.size());
      grp.stream_done   = last && (pos >= run.size());
      grp.bad_reference = clipped;
      fresh_groups.push_back(grp);
    end
    if (last) restart_stream();
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, group_count, msg);
    fail_count++;
  endtask

  // Offer one request, wait for it to be taken, then queue its expected groups
  task automatic push_request(input logic [7:0] code, input logic last,
                              input logic typed = 1'b0, input logic [3:0] count = 4'd0,
                              input logic bad = 1'b0);
    int unsigned pct;
    lzssd_out_t  grp;
    if (req_count < SlowRxItems) begin
      pct = 38;
      idle_mode <= PACE_SLOW_RX;
    end else if (req_count < SlowTxItems) begin
      pct = 71;
      idle_mode <= PACE_SLOW_TX;
    end else begin
      pct = 0;
      idle_mode <= PACE_FULL;
    end
    if ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    in_valid_i            <= 1'b1;
    in_data_i.in_byte     <= code;
    in_data_i.stream_last <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    decode_request(code, last);
    if (typed) begin
      grp               = '0;
      grp.lane0         = (count != 4'd0) ? code : 8'h00;
      grp.lane_count    = count;
      grp.run_last      = 1'b1;
      grp.stream_done   = last;
      grp.bad_reference = bad;
      expected_groups.push_back(grp);
    end else begin
      foreach (fresh_groups[i]) expected_groups.push_back(fresh_groups[i]);
    end
    req_count++;
  endtask

  // One stream of well-formed tokens, sometimes cut short or with wild references
  task automatic random_stream(input int unsigned tokens, input logic may_cut);
    logic [7:0]  flags;
    logic [7:0]  offset;
    logic [7:0]  length;
    int unsigned room;
    int unsigned span;
    int unsigned t;
    flags = 8'h00;
    for (t = 0; t < tokens; t++) begin
      if (t % 8 == 0) begin
        flags = 8'($urandom);
        random_count++;
        if (may_cut && $urandom_range(39) == 0) begin
          push_request(flags, 1'b1);
          return;
        end
        push_request(flags, 1'b0);
      end
      if (flags[7 - t % 8]) begin
        room = dec_pos;
        if (room == 0 || $urandom_range(7) == 0) begin
          offset = 8'($urandom);
          length = 8'($urandom);
        end else begin
          offset = 8'($urandom_range((room > 256) ? 255 : room - 1, 0));
          span   = room - offset;
          if (span > 255) span = 255;
          if ($urandom_range(3) == 0) length = 8'($urandom_range(span, span / 2));
          else length = 8'($urandom_range((span < 12) ? span : 12, 0));
        end
        random_count += 2;
        if (may_cut && $urandom_range(19) == 0) begin
          push_request(offset, 1'b1);
          return;
        end
        push_request(offset, 1'b0);
        push_request(length, 1'b0);
      end
      random_count++;
      push_request(8'($urandom), t == tokens - 1);
    end
  endtask

  // Receiver: random stalls per pacing, plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (idle_mode == PACE_FULL && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < ((idle_mode == PACE_SLOW_RX) ? 71 :
                                            (idle_mode == PACE_SLOW_TX) ? 38 : 0));
    end
  end

  // Check each accepted group against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_groups.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want_group = expected_groups.pop_front();
        got_lanes  = {out_data_o.lane0, out_data_o.lane1, out_data_o.lane2,
                      out_data_o.lane3, out_data_o.lane4, out_data_o.lane5,
                      out_data_o.lane6, out_data_o.lane7};
        want_lanes = {want_group.lane0, want_group.lane1, want_group.lane2,
                      want_group.lane3, want_group.lane4, want_group.lane5,
                      want_group.lane6, want_group.lane7};
        for (lane_idx = 0; lane_idx < Lanes; lane_idx++) begin
          if (got_lanes[63 - 8 * lane_idx -: 8] !== want_lanes[63 - 8 * lane_idx -: 8])
            report_mismatch($sformatf("lane%0d got %h expected %h", lane_idx,
                                      got_lanes[63 - 8 * lane_idx -: 8],
                                      want_lanes[63 - 8 * lane_idx -: 8]));
        end
        if (out_data_o.lane_count !== want_group.lane_count)
          report_mismatch($sformatf("lane_count got %0d expected %0d",
                                    out_data_o.lane_count, want_group.lane_count));
        if (out_data_o.run_last !== want_group.run_last)
          report_mismatch($sformatf("run_last got %b expected %b",
                                    out_data_o.run_last, want_group.run_last));
        if (out_data_o.stream_done !== want_group.stream_done)
          report_mismatch($sformatf("stream_done got %b expected %b",
                                    out_data_o.stream_done, want_group.stream_done));
        if (out_data_o.bad_reference !== want_group.bad_reference)
          report_mismatch($sformatf("bad_reference got %b expected %b",
                                    out_data_o.bad_reference, want_group.bad_reference));
      end
      group_count++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    restart_stream();
    // code, last, typed, count, bad
    dir_rows = '{
      '{8'h00, 1'b0, 1'b0, 4'd0, 1'b0},  // flag: eight literals
      '{8'h00, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'h01, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'h80, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'h5A, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'hA5, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'h7F, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'hFE, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 4'd0, 1'b0},  // flag: eight matches
      '{8'h00, 1'b0, 1'b0, 4'd0, 1'b0},  // full copy of the first eight bytes
      '{8'h08, 1'b0, 1'b0, 4'd0, 1'b0},
      '{8'h3C, 1'b0, 1'b0, 4'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 4'd0, 1'b0},  // reference past the output: clipped
      '{8'hFF, 1'b0, 1'b0, 4'd0, 1'b0},
      '{8'hC3, 1'b0, 1'b1, 4'd1, 1'b1},
      '{8'h00, 1'b0, 1'b0, 4'd0, 1'b0},  // zero-length match
      '{8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
      '{8'h99, 1'b0, 1'b1, 4'd1, 1'b0},
      '{8'h10, 1'b1, 1'b1, 4'd0, 1'b0},  // stream ends inside a match
      '{8'h00, 1'b1, 1'b1, 4'd0, 1'b0},  // stream ends on a flag byte
      '{8'h80, 1'b0, 1'b0, 4'd0, 1'b0},  // match on empty history, then end
      '{8'h00, 1'b0, 1'b0, 4'd0, 1'b0},
      '{8'h03, 1'b0, 1'b0, 4'd0, 1'b0},
      '{8'h42, 1'b1, 1'b1, 4'd1, 1'b1}
    };
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed rows
    foreach (dir_rows[i])
      push_request(dir_rows[i].code, dir_rows[i].last, dir_rows[i].typed,
                   dir_rows[i].count, dir_rows[i].bad);

    // random streams; the first one is long enough to fill the history
    random_stream(64, 1'b0);
    while (random_count < RandomItems) begin
      // keep the last stream from running far past the item budget
      stream_len = $urandom_range(48, 3);
      if (stream_len > (RandomItems - random_count) / 2 + 1)
        stream_len = (RandomItems - random_count) / 2 + 1;
      random_stream(stream_len, 1'b1);
    end

    // drain
    in_valid_i <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lzssd_pkg.sv
rtl/lzssd_history.sv
rtl/lzss_flag_byte_decoder.sv
bench/tb_lzss_flag_byte_decoder.sv
